// File: rtl/aps_pkg.sv
// Shared types, constants and table functions for the stereo allpass phaser.
`default_nettype none
package aps_pkg;

    // Default sizes handed to the top level
    localparam int MAX_STAGES_DEF      = 24;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Configuration register indexes
    localparam logic [2:0] REG_STEP   = 3'd0;
    localparam logic [2:0] REG_STAGES = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_FB     = 3'd3;
    localparam logic [2:0] REG_MIX    = 3'd4;

    // Register values after reset
    localparam logic [31:0] STEP_RST   = 32'd44739;
    localparam logic [4:0]  STAGES_RST = 5'd4;
    localparam logic [15:0] DEPTH_RST  = 16'd32768;
    localparam logic [14:0] FB_RST     = 15'd0;
    localparam logic [15:0] MIX_RST    = 16'd16384;

    // Q15 constants
    localparam logic [15:0] Q_ONE    = 16'd32768;
    localparam logic [14:0] FB_LIMIT = 15'd32440;
    localparam logic [15:0] BASE_OFS = 16'd6554;
    localparam logic [15:0] SWEEP_K  = 16'd22938;
    localparam logic [15:0] K_MIN    = 16'd3277;
    localparam logic [15:0] K_MAX    = 16'd31130;
    localparam logic [15:0] TREM_K   = 16'd9830;

    // Divide by 20: floor(n * RECIP_20 / 2^RECIP_SHIFT) is exact for n below 2^23
    localparam logic [23:0] RECIP_20    = 24'd6710887;
    localparam int          RECIP_SHIFT = 27;

    localparam int PROD_W = 57;

    typedef struct packed {
        logic [31:0] step;
        logic [4:0]  stages;
        logic [15:0] depth;
        logic [14:0] fb;
        logic [15:0] mix;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LFO,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_K1, ST_K2, ST_K3, ST_K4,
        ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_LFO,
        OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
        OP_K1, OP_K2, OP_K3, OP_K4,
        OP_W1, OP_W2, OP_W3, OP_W4, OP_W5, OP_W6
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic last_stage;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint rsr_l(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Quarter-wave sine entry, evaluated at elaboration
    function automatic logic [15:0] quarter_sine(input int q, input int tb);
        longint x;
        longint x2;
        longint p;
        x  = longint'(q) <<< (30 - (tb - 2));
        x2 = rsr_l(x * x, 30);
        p  = 172272;
        p  = rsr_l(p * x2, 30) - 5026997;
        p  = rsr_l(p * x2, 30) + 85569303;
        p  = rsr_l(p * x2, 30) - 693598668;
        p  = rsr_l(p * x2, 30) + 1686629713;
        p  = rsr_l(p * x, 30);
        p  = rsr_l(p, 15);
        if (p < 0) begin
            p = 0;
        end
        if (p > 32768) begin
            p = 32768;
        end
        return 16'(p);
    endfunction

endpackage
`default_nettype wire

// File: rtl/aps_ctrl.sv
// Sequencer for one sample: LFO, coefficient, stage loop and output mix.
`default_nettype none
module aps_ctrl
    import aps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_LFO;
            ST_LFO:  n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_M4;
            ST_M4:   n_state = ST_M5;
            ST_M5:   n_state = ST_M6;
            ST_M6:   n_state = ST_K1;
            ST_K1:   n_state = ST_K2;
            ST_K2:   n_state = ST_K3;
            ST_K3:   n_state = ST_K4;
            ST_K4:   n_state = i_stat.last_stage ? ST_W1 : ST_K1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_W3;
            ST_W3:   n_state = ST_W4;
            ST_W4:   n_state = ST_W5;
            ST_W5:   n_state = ST_W6;
            ST_W6:   if (i_stat.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.op   = i_in_valid ? OP_LOAD : OP_NONE;
            end
            ST_LFO:  o_cmd.op = OP_LFO;
            ST_M1:   o_cmd.op = OP_M1;
            ST_M2:   o_cmd.op = OP_M2;
            ST_M3:   o_cmd.op = OP_M3;
            ST_M4:   o_cmd.op = OP_M4;
            ST_M5:   o_cmd.op = OP_M5;
            ST_M6:   o_cmd.op = OP_M6;
            ST_K1:   o_cmd.op = OP_K1;
            ST_K2:   o_cmd.op = OP_K2;
            ST_K3:   o_cmd.op = OP_K3;
            ST_K4:   o_cmd.op = OP_K4;
            ST_W1:   o_cmd.op = OP_W1;
            ST_W2:   o_cmd.op = OP_W2;
            ST_W3:   o_cmd.op = OP_W3;
            ST_W4:   o_cmd.op = OP_W4;
            ST_W5:   o_cmd.op = OP_W5;
            ST_W6:   o_cmd.op = OP_W6;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/aps_dp.sv
// Datapath: LFO, shared multiplier, stage history memory and output registers.
`default_nettype none
module aps_dp
    import aps_pkg::*;
#(
    parameter int MAX_STAGES      = MAX_STAGES_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cfg                          i_cfg,
    input  wire logic                          i_hist_clear,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_left_out,
    output logic signed [SAMPLE_BITS-1:0]      o_right_out
);

    localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int TB = SINE_TABLE_BITS;
    localparam int QN = 1 << (TB - 2);
    localparam logic signed [63:0] SMP_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMP_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [63:0] v);
        if (v > SMP_MAX) begin
            return SAMPLE_BITS'(SMP_MAX);
        end
        if (v < SMP_MIN) begin
            return SAMPLE_BITS'(SMP_MIN);
        end
        return SAMPLE_BITS'(v);
    endfunction

    // Quarter-wave table, constant
    logic [15:0] w_qtab [QN+1];
    for (genvar g = 0; g <= QN; g++) begin : g_qtab
        assign w_qtab[g] = quarter_sine(g, TB);
    end

    logic [31:0]                   r_phase;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [16:0]            r_s;
    logic signed [16:0]            r_c;
    logic signed [PROD_W-1:0]      r_prod;
    logic [15:0]                   r_base;
    logic [15:0]                   r_tl;
    logic [15:0]                   r_tr;
    logic signed [31:0]            r_filt;
    logic signed [31:0]            r_fbv;
    logic signed [31:0]            r_wl;
    logic signed [31:0]            r_wr;
    logic signed [47:0]            r_dry;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_valid;
    logic [IW:0]                   r_i;
    logic [63:0]                   r_mem [MAX_STAGES];
    logic [63:0]                   r_rd;
    logic                          r_rdv;
    logic [MAX_STAGES-1:0]         r_hv;

    // Saturated settings and stage count in use
    logic [15:0] w_depth;
    logic [14:0] w_fb;
    logic [15:0] w_mix;
    logic [16:0] w_dmix;
    logic [IW:0] w_n;

    always_comb begin
        w_depth = (i_cfg.depth > Q_ONE) ? Q_ONE : i_cfg.depth;
        w_fb    = (i_cfg.fb > FB_LIMIT) ? FB_LIMIT : i_cfg.fb;
        w_mix   = (i_cfg.mix > Q_ONE) ? Q_ONE : i_cfg.mix;
        w_dmix  = 17'd32768 - {1'b0, w_mix};
        if (i_cfg.stages == 5'd0) begin
            w_n = (IW+1)'(1);
        end else if (32'(i_cfg.stages) > 32'(MAX_STAGES)) begin
            w_n = (IW+1)'(MAX_STAGES);
        end else begin
            w_n = (IW+1)'(i_cfg.stages);
        end
    end

    // Sine and cosine lookups from the top bits of the phase
    logic [TB-1:0]      w_is;
    logic [TB-1:0]      w_ic;
    logic [TB-2:0]      w_as;
    logic [TB-2:0]      w_ac;
    logic signed [16:0] w_sin;
    logic signed [16:0] w_cos;

    always_comb begin
        w_is = r_phase[31 -: TB];
        w_ic = w_is + TB'(QN);
        w_as = w_is[TB-2] ? ((TB-1)'(QN) - {1'b0, w_is[TB-3:0]}) : {1'b0, w_is[TB-3:0]};
        w_ac = w_ic[TB-2] ? ((TB-1)'(QN) - {1'b0, w_ic[TB-3:0]}) : {1'b0, w_ic[TB-3:0]};
        w_sin = w_is[TB-1] ? -$signed({1'b0, w_qtab[w_as]}) : $signed({1'b0, w_qtab[w_as]});
        w_cos = w_ic[TB-1] ? -$signed({1'b0, w_qtab[w_ac]}) : $signed({1'b0, w_qtab[w_ac]});
    end

    // Product rounded to Q15 and stage terms
    logic signed [PROD_W-1:0] w_pr15;
    logic signed [17:0]       w_mod;
    logic [29:0]              w_q;
    logic [15:0]              w_k;
    logic signed [31:0]       w_ih;
    logic signed [31:0]       w_oh;
    logic signed [32:0]       w_diff;
    logic signed [31:0]       w_y;
    logic signed [63:0]       w_omix;
    logic [23:0]              w_ip20;

    always_comb begin
        w_pr15 = (r_prod + $signed(PROD_W'(16384))) >>> 15;
        w_mod  = (18'sd32769 + 18'(r_s)) >>> 1;
        w_q    = r_prod[PROD_W-1:RECIP_SHIFT];
        if (w_q < 30'(K_MIN)) begin
            w_k = K_MIN;
        end else if (w_q > 30'(K_MAX)) begin
            w_k = K_MAX;
        end else begin
            w_k = w_q[15:0];
        end
        w_ih   = r_rdv ? $signed(r_rd[63:32]) : 32'sd0;
        w_oh   = r_rdv ? $signed(r_rd[31:0]) : 32'sd0;
        w_diff = 33'(w_oh) - 33'(r_filt);
        w_y    = sat32(64'(w_ih) + 64'(w_pr15));
        w_omix = (64'(r_dry) + 64'(r_prod) + 64'sd16384) >>> 15;
        w_ip20 = 24'(r_i) + 24'd20;
    end

    // Shared multiplier operand select
    logic signed [32:0]       w_a;
    logic signed [23:0]       w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic                     w_mul_en;

    always_comb begin
        w_a      = '0;
        w_b      = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            OP_M1: begin
                w_a = 33'(w_mod);
                w_b = $signed({8'd0, w_depth});
            end
            OP_M2: begin
                w_a = w_pr15[32:0];
                w_b = $signed({8'd0, SWEEP_K});
            end
            OP_M3: begin
                w_a = 33'(r_fbv);
                w_b = $signed({9'd0, w_fb});
            end
            OP_M4: begin
                w_a = 33'(r_s);
                w_b = $signed({8'd0, TREM_K});
            end
            OP_M5: begin
                w_a = 33'(r_c);
                w_b = $signed({8'd0, TREM_K});
            end
            OP_K1: begin
                w_a = $signed({17'd0, r_base});
                w_b = $signed(w_ip20);
            end
            OP_K2: begin
                w_a = r_prod[32:0] + 33'sd10;
                w_b = $signed(RECIP_20);
            end
            OP_K3: begin
                w_a = w_diff;
                w_b = $signed({8'd0, w_k});
            end
            OP_W1: begin
                w_a = 33'(r_filt);
                w_b = $signed({8'd0, r_tl});
            end
            OP_W2: begin
                w_a = 33'(r_filt);
                w_b = $signed({8'd0, r_tr});
            end
            OP_W3: begin
                w_a = 33'(r_x);
                w_b = $signed({7'd0, w_dmix});
            end
            OP_W4: begin
                w_a = 33'(r_wl);
                w_b = $signed({8'd0, w_mix});
            end
            OP_W5: begin
                w_a = 33'(r_wr);
                w_b = $signed({8'd0, w_mix});
            end
            default: w_mul_en = 1'b0;
        endcase
        w_mul = w_a * w_b;
    end

    logic w_out_free;
    logic w_hwe;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_hwe      = (i_cmd.op == OP_K4);

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul;
        end
        case (i_cmd.op)
            OP_LOAD: r_x <= i_sample_in;
            OP_LFO: begin
                r_s <= w_sin;
                r_c <= w_cos;
            end
            OP_M3: r_base <= w_pr15[15:0] + BASE_OFS;
            OP_M4: r_filt <= sat32(64'(r_x) + 64'(w_pr15));
            OP_M5: r_tl <= w_pr15[15:0] + Q_ONE;
            OP_M6: r_tr <= w_pr15[15:0] + Q_ONE;
            OP_K4: r_filt <= w_y;
            OP_W2: r_wl <= sat32(64'(w_pr15));
            OP_W3: r_wr <= sat32(64'(w_pr15));
            OP_W4: r_dry <= r_prod[47:0];
            OP_W5: r_left <= sat_smp(w_omix);
            OP_W6: begin
                if (w_out_free) begin
                    r_out_left  <= r_left;
                    r_out_right <= sat_smp(w_omix);
                end
            end
            default: ;
        endcase
    end

    // Control registers: phase, feedback, stage index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_fbv       <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_phase <= r_phase + i_cfg.step;
            end
            if (i_cmd.op == OP_W1) begin
                r_fbv <= r_filt;
            end
            if (i_cmd.op == OP_M6) begin
                r_i <= '0;
            end else if (w_hwe) begin
                r_i <= r_i + (IW+1)'(1);
            end
            if (i_cmd.op == OP_W6 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage history: {input, output} per stage, valid bits mark written entries
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_mem[r_i[IW-1:0]] <= {r_filt, w_y};
        end
        r_rd <= r_mem[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_hist_clear) begin
            r_hv  <= '0;
            r_rdv <= 1'b0;
        end else begin
            if (w_hwe) begin
                r_hv[r_i[IW-1:0]] <= 1'b1;
            end
            r_rdv <= r_hv[r_i[IW-1:0]];
        end
    end

    assign o_stat.last_stage = ((r_i + (IW+1)'(1)) == w_n);
    assign o_stat.out_free   = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_left_out        = r_out_left;
    assign o_right_out       = r_out_right;

endmodule
`default_nettype wire

// File: rtl/allpass_phaser_stereo.sv
// Each sample runs the LFO, coefficient, stage loop and output mix steps in turn, with
// N = stages in use (1..MAX_STAGES); the stage loop runs on the one shared multiplier
// (four steps per stage). No new sample is taken before the last result is registered.
// The next sample is taken while a finished result still waits at the output register.
// Reset (i_rst_n low, synchronous): LFO phase, feedback and history valid bits clear,
// registers return to their defaults; writing stage_count clears the history too.
`default_nettype none
module allpass_phaser_stereo
    import aps_pkg::*;
#(
    parameter int MAX_STAGES      = MAX_STAGES_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_left_out,
    output logic signed [SAMPLE_BITS-1:0]      o_right_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_wdata
);

    t_cfg     r_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_hist_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step   <= STEP_RST;
            r_cfg.stages <= STAGES_RST;
            r_cfg.depth  <= DEPTH_RST;
            r_cfg.fb     <= FB_RST;
            r_cfg.mix    <= MIX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP:   r_cfg.step   <= i_cfg_wdata;
                REG_STAGES: r_cfg.stages <= i_cfg_wdata[4:0];
                REG_DEPTH:  r_cfg.depth  <= i_cfg_wdata[15:0];
                REG_FB:     r_cfg.fb     <= i_cfg_wdata[14:0];
                REG_MIX:    r_cfg.mix    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_hist_clear = i_cfg_we && (i_cfg_index == REG_STAGES);

    aps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aps_dp #(
        .MAX_STAGES      (MAX_STAGES),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_hist_clear (w_hist_clear),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a sample is in work");

    a_result_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.op == OP_W6))
        else $error("result raised outside the final mix step");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_W6 && w_stat.out_free) |=> !o_in_stall)
        else $error("sequencer did not return to idle after result");

    a_load_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_LOAD) |-> (i_in_valid && !o_in_stall))
        else $error("sample load without an input transfer");
`endif

endmodule
`default_nettype wire
